>>> rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned AesRounds  = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CfgAddrW   = 4;

  localparam logic [CfgAddrW-1:0] AddrKeyLow  = 4'h0;
  localparam logic [CfgAddrW-1:0] AddrKeyHigh = 4'h8;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic [63:0] nonce;
    logic [63:0] ctr;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  valid_bytes;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  valid_bytes;
    logic        last;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] t [10];
    t = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
    return t[r];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 8i+7..8i.
  function automatic block_t next_round_key(input block_t k, input logic [3:0] r);
    block_t n;
    logic [31:0] t;
    t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
         sbox(k[111:104]) ^ rcon(r)};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

  function automatic block_t aes_round(input block_t s, input block_t rk, input logic last);
    block_t t;
    block_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(4*c+i) +: 8] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
      end
    end
    m = t;
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return (last ? t : m) ^ rk;
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes_ifc.sv
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        first_block;
  logic [63:0] nonce_value;
  logic [63:0] data_low_half;
  logic [63:0] data_high_half;
  logic [4:0]  valid_bytes;
  logic        last_block;
  modport source (output valid, first_block, nonce_value, data_low_half, data_high_half,
                  valid_bytes, last_block, input ready);
  modport sink (input valid, first_block, nonce_value, data_low_half, data_high_half,
                valid_bytes, last_block, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low_half;
  logic [63:0] out_high_half;
  logic [4:0]  out_valid_bytes;
  logic        out_last;
  modport source (output valid, out_low_half, out_high_half, out_valid_bytes, out_last,
                  input ready);
  modport sink (input valid, out_low_half, out_high_half, out_valid_bytes, out_last,
                output ready);
endinterface
`default_nettype wire

>>> rtl/aes_front.sv
`default_nettype none
module aes_front #(
  parameter int unsigned Depth = aes_pkg::QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  aes_in_if.sink         in_if,
  output aes_pkg::job_t  job_o,
  output logic           job_valid_o,
  input  wire logic      job_ready_i
);
  import aes_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [63:0] nonce_q, nonce_d, ctr_q, ctr_d;
  job_t        mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;
  job_t          job;

  assign in_if.ready = (cnt_q != (AW+1)'(Depth));
  assign push        = in_if.valid && in_if.ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rd_q];

  always_comb begin
    job.nonce       = in_if.first_block ? in_if.nonce_value : nonce_q;
    job.ctr         = in_if.first_block ? 64'd0 : ctr_q;
    job.data_low    = in_if.data_low_half;
    job.data_high   = in_if.data_high_half;
    job.valid_bytes = in_if.valid_bytes;
    job.last        = in_if.last_block;
    nonce_d = push ? job.nonce : nonce_q;
    ctr_d   = push ? job.ctr + 64'd1 : ctr_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_q <= '0;
      ctr_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      nonce_q <= nonce_d;
      ctr_q   <= ctr_d;
      if (push) begin
        wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/aes_back.sv
`default_nettype none
module aes_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [127:0] key_i,
  input  aes_pkg::job_t     job_i,
  input  wire logic         job_valid_i,
  output logic              job_ready_o,
  aes_out_if.source         out_if
);
  import aes_pkg::*;

  localparam int unsigned NS = AesRounds + 1;

  block_t st_q [NS];
  block_t rk_q [NS];
  side_t  sd_q [NS];
  logic   v_q  [NS];
  logic   adv;
  block_t ks;
  logic [127:0] mask;

  // The whole pipeline moves together when its last stage is free.
  assign adv         = !v_q[NS-1] || out_if.ready;
  assign job_ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {job_i.ctr, job_i.nonce} ^ key_i;
      rk_q[0] <= key_i;
      sd_q[0] <= '{job_i.data_low, job_i.data_high, job_i.valid_bytes, job_i.last};
      for (int r = 1; r < NS; r++) begin
        rk_q[r] <= next_round_key(rk_q[r-1], 4'(r-1));
        st_q[r] <= aes_round(st_q[r-1], next_round_key(rk_q[r-1], 4'(r-1)),
                             (r == AesRounds));
        sd_q[r] <= sd_q[r-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NS; r++) v_q[r] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= job_valid_i;
      for (int r = 1; r < NS; r++) v_q[r] <= v_q[r-1];
    end
  end

  always_comb begin
    for (int i = 0; i < BlockBytes; i++) begin
      mask[8*i +: 8] = (5'(i) < sd_q[NS-1].valid_bytes) ? 8'hff : 8'h00;
    end
    ks = st_q[NS-1] ^ {sd_q[NS-1].data_high, sd_q[NS-1].data_low};
    ks = ks & mask;
  end

  assign out_if.valid           = v_q[NS-1];
  assign out_if.out_low_half    = ks[63:0];
  assign out_if.out_high_half   = ks[127:64];
  assign out_if.out_valid_bytes = sd_q[NS-1].valid_bytes;
  assign out_if.out_last        = sd_q[NS-1].last;
endmodule
`default_nettype wire

>>> rtl/aes128_ctr_block_cipher.sv
`default_nettype none
// AES-128 counter-mode cipher, one 16-byte block per request. The front end
// takes one request per cycle while its queue is not full, loads the nonce
// and clears the counter on a first block, and queues the counter block with
// the data; an eleven-stage round pipeline encrypts it and XORs the data at one
// request per cycle while the output is taken. The user writes the key over APB
// at byte addresses 0 and 8 and must do so only while the block is idle; the
// block does not enforce it. Bytes past the valid count come out as zero.
module aes128_ctr_block_cipher #(
  parameter int unsigned QueueDepth = aes_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aes_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [63:0]                   pwdata,
  output logic      [63:0]                   prdata,
  output logic                               pready,
  aes_in_if.sink                             in_if,
  aes_out_if.source                          out_if
);
  import aes_pkg::*;

  logic [63:0] key_lo_q, key_hi_q;
  job_t        job;
  logic        job_valid, job_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrKeyLow) key_lo_q <= pwdata;
      if (paddr == AddrKeyHigh) key_hi_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrKeyLow) prdata = key_lo_q;
    if (paddr == AddrKeyHigh) prdata = key_hi_q;
  end

  aes_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_if,
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  aes_back u_back (
    .clk_i, .rst_ni, .key_i({key_hi_q, key_lo_q}),
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready), .out_if
  );
endmodule
`default_nettype wire

>>> verif/aes128_ctr_block_cipher_tb.sv
`timescale 1ns / 1ps
module aes128_ctr_block_cipher_tb;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  count;
    logic        last;
  } cipher_out_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  typedef enum int unsigned {RegKeyLow = 0, RegKeyHigh = 1} reg_idx_e;

  class ctr_scoreboard;
    logic [63:0] key_low, key_high, nonce, counter;
    cipher_out_t expected_q[$];
    int unsigned errors;

    function void reset_state();
      key_low = '0; key_high = '0; nonce = '0; counter = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function logic [7:0] sb(logic [7:0] a);
      logic [7:0] t [256];
      t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return t[a];
    endfunction

    function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [127:0] keystream(logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] rc [10];
      logic [7:0] f, a0, a1, a2, a3, al;
      logic [127:0] r;
      rc = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
      for (int i = 0; i < 8; i++) begin
        rk[i] = key_low[8*i +: 8];
        rk[i+8] = key_high[8*i +: 8];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
        if (i % 4 == 0) begin
          f = w[0];
          w[0] = sb(w[1]) ^ rc[i/4-1];
          w[1] = sb(w[2]);
          w[2] = sb(w[3]);
          w[3] = sb(f);
        end
        for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ rk[i];
      for (int rd = 1; rd <= 10; rd++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) t[4*c+i] = sb(s[4*((c+i)%4)+i]);
        if (rd != 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rd+i];
      end
      for (int i = 0; i < 16; i++) r[8*i +: 8] = s[i];
      return r;
    endfunction

    function void note_request(logic first, logic [63:0] nv, logic [63:0] dl,
                               logic [63:0] dh, logic [4:0] cnt, logic lst);
      logic [127:0] ks, dat, res;
      int unsigned n;
      cipher_out_t e;
      if (first) begin
        nonce = nv;
        counter = '0;
      end
      n = (cnt > 16) ? 16 : cnt;
      ks = keystream({counter, nonce});
      dat = {dh, dl};
      for (int i = 0; i < 16; i++) res[8*i +: 8] = (i < n) ? dat[8*i +: 8] ^ ks[8*i +: 8] : 8'h00;
      counter = counter + 64'd1;
      e.low = res[63:0]; e.high = res[127:64]; e.count = cnt; e.last = lst;
      expected_q.push_back(e);
    endfunction

    function void check_result(cipher_out_t got);
      cipher_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.low !== e.low) begin
        $error("out_low_half expected %h actual %h", e.low, got.low); errors++;
      end
      if (got.high !== e.high) begin
        $error("out_high_half expected %h actual %h", e.high, got.high); errors++;
      end
      if (got.count !== e.count) begin
        $error("out_valid_bytes expected %0d actual %0d", e.count, got.count); errors++;
      end
      if (got.last !== e.last) begin
        $error("out_last expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  aes_in_if in_ch();
  aes_out_if out_ch();

  ctr_scoreboard board;
  bit quiet_phase = 1'b0;
  int unsigned hold_off = 0;
  int unsigned idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  aes128_ctr_block_cipher i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_block = 1'b0;
    in_ch.nonce_value = '0;
    in_ch.data_low_half = '0;
    in_ch.data_high_half = '0;
    in_ch.valid_bytes = 5'd16;
    in_ch.last_block = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.out_low_half, out_ch.out_high_half,
                          out_ch.out_valid_bytes, out_ch.out_last});
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic write_key(reg_idx_e idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= (idx == RegKeyLow) ? AddrKeyLow : AddrKeyHigh;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegKeyLow) board.key_low = value;
    else board.key_high = value;
  endtask

  task automatic send_block(logic first, logic [63:0] nv, logic [63:0] dl,
                            logic [63:0] dh, logic [4:0] cnt, logic lst);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_block <= first;
    in_ch.nonce_value <= nv;
    in_ch.data_low_half <= dl;
    in_ch.data_high_half <= dh;
    in_ch.valid_bytes <= cnt;
    in_ch.last_block <= lst;
    @(posedge clk_i iff in_ch.ready);
    board.note_request(first, nv, dl, dh, cnt, lst);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic run_messages(int unsigned blocks);
    int unsigned left, len, pick;
    logic [4:0] cnt;
    left = blocks;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      for (int unsigned k = 0; k < len && left > 0; k++) begin
        pick = $urandom_range(0, 9);
        cnt = (k == len - 1 || pick == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
        if (pick == 1) cnt = 5'($urandom_range(1, 16));
        send_block((k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                   rand64(), rand64(), rand64(), cnt,
                   (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
        left--;
      end
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_block(1'b0, '0, '0, '0, 5'd16, 1'b0);
    send_block(1'b0, '1, '1, '1, 5'd16, 1'b1);
    wait_drained();
    write_key(RegKeyLow, 64'h0);
    wait_drained();
    write_key(RegKeyLow, 64'ha6d2ae2816157e2b);
    write_key(RegKeyHigh, 64'h3c4fcf098815f7ab);
    send_block(1'b1, 64'hfffefdfcfbfaf9f8, 64'h1122334455667788, 64'h99aabbccddeeff00, 5'd16, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd1, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd0, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd17, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd31, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd8, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd9, 1'b0);
    send_block(1'b0, '0, '1, '1, 5'd15, 1'b1);
    send_block(1'b1, '1, 64'h0, 64'h0, 5'd16, 1'b1);
    wait_drained();

    write_key(RegKeyLow, '1);
    write_key(RegKeyHigh, '1);
    send_block(1'b1, 64'h5555aaaa5555aaaa, rand64(), rand64(), 5'd16, 1'b0);
    hold_off = 60;
    for (int i = 0; i < 20; i++) send_block(1'b0, rand64(), rand64(), rand64(), 5'd16, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      write_key(RegKeyLow, rand64());
      write_key(RegKeyHigh, rand64());
      if (phase == 4) quiet_phase = 1'b1;
      run_messages(100);
      wait_drained();
    end

    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/aes_pkg.sv
rtl/aes_ifc.sv
rtl/aes_front.sv
rtl/aes_back.sv
rtl/aes128_ctr_block_cipher.sv
verif/aes128_ctr_block_cipher_tb.sv
